/* hw/rtl/tdrc_pkg.sv */
// Shared types, constants and codes for the trace digest replay checker.
package tdrc_pkg;

   localparam logic [63:0] DIGEST_BASIS = 64'h517cc1b727220a95;
   localparam logic [63:0] DIGEST_PRIME = 64'h00000100000001B3;
   localparam int unsigned EVENT_BYTES = 24;

   typedef enum logic [2:0] {
      MODE_RECORD     = 3'd0,
      MODE_LOAD_REF   = 3'd1,
      MODE_VERIFY     = 3'd2,
      MODE_RESET_LIVE = 3'd3,
      MODE_BEGIN_REF  = 3'd4,
      MODE_DROP_REF   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      STAT_MATCH  = 3'd0,
      STAT_LENGTH = 3'd1,
      STAT_KIND   = 3'd2,
      STAT_ENTITY = 3'd3,
      STAT_AUX    = 3'd4,
      STAT_DIGEST = 3'd5
   } status_type;

   // One FNV-1a byte step; prime is 2^40 + 0x1b3, so the product is shifts and adds.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

/* hw/rtl/tdrc_ram.sv */
// Generic single-port RAM with registered read.
module tdrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

/* hw/rtl/trace_digest_replay_checker.sv */
// Top level: trace recorder, byte-serial FNV-1a digest with a non-FNV basis, and replay verify.
// Record and load: byte-serial hashing of the 24-byte event, one byte per cycle;
// once the matching store is full they only count the event and skip the hash.
// Verify: compares stored entries pairwise, one RAM read per compared pair.
// One transaction is in work at a time.
// Reset (synchronous, active high) clears counters, flags and sets both digests to the basis.
module trace_digest_replay_checker #(
   parameter int TRACE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata: mode[2:0], event_kind[10:3], entity_ident[74:11],
   // aux_value[138:75], ref_sequence[170:139], zero pad to 176
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: status[2:0], first_diff[34:3], live_digest[98:35],
   // ref_digest[162:99], live_count[194:163], zero pad to 200
   output logic [199:0] rsp_tdata
);
   import tdrc_pkg::*;

   localparam int AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
   localparam int RD = 1 << AW;

   typedef enum logic [2:0] {S_IDLE, S_HASH, S_RD, S_CMP, S_DONE} state_type;

   state_type    state_ff;
   logic [2:0]   mode_ff;
   logic [7:0]   kind_ff;
   logic [63:0]  ent_ff, aux_ff;
   logic [191:0] shift_ff;
   logic [4:0]   bcnt_ff;
   logic [63:0]  hacc_ff;
   logic [31:0]  live_cnt_ff, ref_cnt_ff, idx_ff;
   logic         ref_loaded_ff;
   logic [63:0]  live_hash_ff, ref_hash_ff;
   logic [2:0]   status_ff;
   logic [31:0]  div_ff;

   logic [2:0]  in_mode;
   logic [7:0]  in_kind;
   logic [63:0] in_ent, in_aux;
   logic [31:0] in_seq;
   assign in_mode = req_tdata[2:0];
   assign in_kind = req_tdata[10:3];
   assign in_ent  = req_tdata[74:11];
   assign in_aux  = req_tdata[138:75];
   assign in_seq  = req_tdata[170:139];

   logic live_room, ref_room;
   assign live_room = live_cnt_ff < 32'(TRACE_DEPTH);
   assign ref_room  = ref_cnt_ff  < 32'(TRACE_DEPTH);

   // verify with a loaded reference whose length differs from the live trace
   logic len_diff;
   assign len_diff = (in_mode == MODE_VERIFY) && ref_loaded_ff && (live_cnt_ff != ref_cnt_ff);

   // RAM control
   logic          live_we, ref_we;
   logic [AW-1:0] live_addr, ref_addr;
   logic [7:0]    lk_q, rk_q;
   logic [63:0]   le_q, la_q, re_q, ra_q;
   assign live_we = (state_ff == S_HASH) && (mode_ff == MODE_RECORD) && (bcnt_ff == 5'd0);
   assign ref_we  = (state_ff == S_HASH) && (mode_ff == MODE_LOAD_REF) && (bcnt_ff == 5'd0);
   assign live_addr = (state_ff == S_HASH) ? live_cnt_ff[AW-1:0] : idx_ff[AW-1:0];
   assign ref_addr  = (state_ff == S_HASH) ? ref_cnt_ff[AW-1:0]  : idx_ff[AW-1:0];

   tdrc_ram #(.WIDTH(8),  .DEPTH(RD)) u_lk (.clock, .wr_en(live_we), .addr(live_addr),
      .wr_data(kind_ff), .rd_data(lk_q));
   tdrc_ram #(.WIDTH(64), .DEPTH(RD)) u_le (.clock, .wr_en(live_we), .addr(live_addr),
      .wr_data(ent_ff), .rd_data(le_q));
   tdrc_ram #(.WIDTH(64), .DEPTH(RD)) u_la (.clock, .wr_en(live_we), .addr(live_addr),
      .wr_data(aux_ff), .rd_data(la_q));
   tdrc_ram #(.WIDTH(8),  .DEPTH(RD)) u_rk (.clock, .wr_en(ref_we), .addr(ref_addr),
      .wr_data(kind_ff), .rd_data(rk_q));
   tdrc_ram #(.WIDTH(64), .DEPTH(RD)) u_re (.clock, .wr_en(ref_we), .addr(ref_addr),
      .wr_data(ent_ff), .rd_data(re_q));
   tdrc_ram #(.WIDTH(64), .DEPTH(RD)) u_ra (.clock, .wr_en(ref_we), .addr(ref_addr),
      .wr_data(aux_ff), .rd_data(ra_q));

   logic [31:0] cmp_n;
   assign cmp_n = (live_cnt_ff < 32'(TRACE_DEPTH)) ? live_cnt_ff : 32'(TRACE_DEPTH);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata  = {5'd0, live_cnt_ff, ref_hash_ff, live_hash_ff, div_ff, status_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_cnt_ff   <= '0;
         ref_cnt_ff    <= '0;
         ref_loaded_ff <= 1'b0;
         live_hash_ff  <= DIGEST_BASIS;
         ref_hash_ff   <= DIGEST_BASIS;
         status_ff     <= STAT_MATCH;
         div_ff        <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               mode_ff   <= in_mode;
               kind_ff   <= in_kind;
               ent_ff    <= in_ent;
               aux_ff    <= in_aux;
               bcnt_ff   <= '0;
               idx_ff    <= '0;
               status_ff <= len_diff ? STAT_LENGTH : STAT_MATCH;
               div_ff    <= len_diff ? ((live_cnt_ff < ref_cnt_ff) ? live_cnt_ff : ref_cnt_ff)
                                     : '0;
               case (in_mode)
                  MODE_RECORD: begin
                     if (live_room) begin
                        shift_ff <= {in_aux, in_ent, 24'd0, in_kind, live_cnt_ff};
                        hacc_ff  <= live_hash_ff;
                        state_ff <= S_HASH;
                     end else begin
                        live_cnt_ff <= live_cnt_ff + 32'd1;
                        state_ff    <= S_DONE;
                     end
                  end
                  MODE_LOAD_REF: begin
                     ref_loaded_ff <= 1'b1;
                     if (ref_room) begin
                        shift_ff <= {in_aux, in_ent, 24'd0, in_kind, in_seq};
                        hacc_ff  <= ref_hash_ff;
                        state_ff <= S_HASH;
                     end else begin
                        ref_cnt_ff <= ref_cnt_ff + 32'd1;
                        state_ff   <= S_DONE;
                     end
                  end
                  MODE_VERIFY: begin
                     state_ff <= (ref_loaded_ff && !len_diff) ? S_RD : S_DONE;
                  end
                  MODE_RESET_LIVE: begin
                     live_cnt_ff  <= '0;
                     live_hash_ff <= DIGEST_BASIS;
                     state_ff     <= S_DONE;
                  end
                  MODE_BEGIN_REF: begin
                     ref_cnt_ff    <= '0;
                     ref_loaded_ff <= 1'b1;
                     ref_hash_ff   <= DIGEST_BASIS;
                     state_ff      <= S_DONE;
                  end
                  MODE_DROP_REF: begin
                     ref_cnt_ff    <= '0;
                     ref_loaded_ff <= 1'b0;
                     ref_hash_ff   <= DIGEST_BASIS;
                     state_ff      <= S_DONE;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_HASH: begin
               // fold one byte per cycle, low byte first
               hacc_ff  <= fnv_step(hacc_ff, shift_ff[7:0]);
               shift_ff <= shift_ff >> 8;
               bcnt_ff  <= bcnt_ff + 5'd1;
               if (bcnt_ff == 5'(EVENT_BYTES - 1)) begin
                  if (mode_ff == MODE_RECORD) begin
                     live_hash_ff <= fnv_step(hacc_ff, shift_ff[7:0]);
                     live_cnt_ff  <= live_cnt_ff + 32'd1;
                  end else begin
                     ref_hash_ff <= fnv_step(hacc_ff, shift_ff[7:0]);
                     ref_cnt_ff  <= ref_cnt_ff + 32'd1;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_RD: begin
               if (idx_ff >= cmp_n) begin
                  if (live_hash_ff != ref_hash_ff) status_ff <= STAT_DIGEST;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (lk_q != rk_q) begin
                  status_ff <= STAT_KIND;
                  div_ff    <= idx_ff;
                  state_ff  <= S_DONE;
               end else if (le_q != re_q) begin
                  status_ff <= STAT_ENTITY;
                  div_ff    <= idx_ff;
                  state_ff  <= S_DONE;
               end else if (la_q != ra_q) begin
                  status_ff <= STAT_AUX;
                  div_ff    <= idx_ff;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + 32'd1;
                  state_ff <= S_RD;
               end
            end
            S_DONE: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* hw/rtl/tdrc_checker.sv */
// Port-level checker for the trace digest replay checker, bound to the top level.
module tdrc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [175:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata
);
   import tdrc_pkg::*;

   // no new request taken while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken during result");

   // result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed");

   // status stays in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= STAT_DIGEST) else $error("bad status");

   // non-verify modes report match
   a_nonverify: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[2:0] != MODE_VERIFY |=> rsp_tdata[2:0] == STAT_MATCH)
      else $error("status on non-verify");
endmodule

bind trace_digest_replay_checker tdrc_checker u_tdrc_checker (.*);

/* sim/trace_digest_replay_checker_test.sv */
// Self-checking testbench for the trace digest replay checker.
module trace_digest_replay_checker_test;
   import tdrc_pkg::*;

   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;
   localparam int DEPTH = 256;
   localparam int STALL_LIMIT = 6000;
   localparam int RANDOM_ITEMS = 150;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] index;
      logic [63:0] live_digest;
      logic [63:0] ref_digest;
      logic [31:0] count;
   } verdict_type;

   class digest_scoreboard_type;
      logic [7:0]  live_kind[DEPTH];
      logic [63:0] live_ent[DEPTH];
      logic [63:0] live_aux[DEPTH];
      logic [7:0]  ref_kind[DEPTH];
      logic [63:0] ref_ent[DEPTH];
      logic [63:0] ref_aux[DEPTH];
      logic [31:0] live_cnt, ref_cnt;
      logic        ref_valid;
      logic [63:0] live_h, ref_h;
      verdict_type pending[$];
      int          errors;
      int          status_seen[8];

      function new();
         live_cnt = 0;
         ref_cnt = 0;
         ref_valid = 0;
         live_h = DIGEST_BASIS;
         ref_h = DIGEST_BASIS;
         errors = 0;
      endfunction

      function logic [63:0] absorb(logic [63:0] h, logic [63:0] v, int n);
         for (int b = 0; b < n; b++) begin
            h = h ^ ((v >> (8 * b)) & 64'hff);
            h = h * DIGEST_PRIME;
         end
         return h;
      endfunction

      function logic [63:0] fold(logic [63:0] h, logic [31:0] seq, logic [7:0] kind,
                                 logic [63:0] ent, logic [63:0] aux);
         h = absorb(h, {32'd0, seq}, 4);
         h = absorb(h, {56'd0, kind}, 4);
         h = absorb(h, ent, 8);
         return absorb(h, aux, 8);
      endfunction

      // Predict the single report caused by one accepted transaction.
      function void note_request(logic [175:0] d);
         logic [2:0]  mode;
         logic [7:0]  kind;
         logic [63:0] ent, aux;
         logic [31:0] seq, n;
         verdict_type v;
         mode = d[2:0];
         kind = d[10:3];
         ent = d[74:11];
         aux = d[138:75];
         seq = d[170:139];
         v.status = STAT_MATCH;
         v.index = 0;
         case (mode)
            MODE_RECORD: begin
               if (live_cnt < DEPTH) begin
                  live_kind[live_cnt] = kind;
                  live_ent[live_cnt] = ent;
                  live_aux[live_cnt] = aux;
                  live_h = fold(live_h, live_cnt, kind, ent, aux);
               end
               live_cnt++;
            end
            MODE_LOAD_REF: begin
               ref_valid = 1;
               if (ref_cnt < DEPTH) begin
                  ref_kind[ref_cnt] = kind;
                  ref_ent[ref_cnt] = ent;
                  ref_aux[ref_cnt] = aux;
                  ref_h = fold(ref_h, seq, kind, ent, aux);
               end
               ref_cnt++;
            end
            MODE_VERIFY: begin
               if (ref_valid) begin
                  if (live_cnt != ref_cnt) begin
                     v.status = STAT_LENGTH;
                     v.index = live_cnt < ref_cnt ? live_cnt : ref_cnt;
                  end else begin
                     n = live_cnt < DEPTH ? live_cnt : DEPTH;
                     for (int i = 0; i < n && v.status == STAT_MATCH; i++) begin
                        if (live_kind[i] != ref_kind[i]) v.status = STAT_KIND;
                        else if (live_ent[i] != ref_ent[i]) v.status = STAT_ENTITY;
                        else if (live_aux[i] != ref_aux[i]) v.status = STAT_AUX;
                        if (v.status != STAT_MATCH) v.index = i;
                     end
                     if (v.status == STAT_MATCH && live_h != ref_h) v.status = STAT_DIGEST;
                  end
                  status_seen[v.status]++;
               end
            end
            MODE_RESET_LIVE: begin
               live_cnt = 0;
               live_h = DIGEST_BASIS;
            end
            MODE_BEGIN_REF: begin
               ref_cnt = 0;
               ref_valid = 1;
               ref_h = DIGEST_BASIS;
            end
            MODE_DROP_REF: begin
               ref_cnt = 0;
               ref_valid = 0;
               ref_h = DIGEST_BASIS;
            end
            default: ;
         endcase
         v.live_digest = live_h;
         v.ref_digest = ref_h;
         v.count = live_cnt;
         pending.push_back(v);
      endfunction

      function void check_report(logic [199:0] d);
         verdict_type v;
         if (pending.size() == 0) begin
            $display("%0t: unexpected report %h", $realtime, d);
            errors++;
            return;
         end
         v = pending.pop_front();
         if (d[2:0] !== v.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, v.status, d[2:0]);
            errors++;
         end
         if (d[34:3] !== v.index) begin
            $display("%0t: index exp %0d got %0d", $realtime, v.index, d[34:3]);
            errors++;
         end
         if (d[98:35] !== v.live_digest) begin
            $display("%0t: live digest exp %h got %h", $realtime, v.live_digest, d[98:35]);
            errors++;
         end
         if (d[162:99] !== v.ref_digest) begin
            $display("%0t: ref digest exp %h got %h", $realtime, v.ref_digest, d[162:99]);
            errors++;
         end
         if (d[194:163] !== v.count) begin
            $display("%0t: live count exp %0d got %0d", $realtime, v.count, d[194:163]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [199:0] rsp_tdata;

   digest_scoreboard_type sb = new();
   bit quiet = 0;
   int stall_cycles = 0;
   int accepted = 0;

   trace_digest_replay_checker u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata);
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_report(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Receiver: open stretches mixed with stall bursts, steady ready near the end.
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = 1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         if (!quiet) begin
            rsp_tready = 0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end
      end
   end

   task automatic send(logic [2:0] mode, logic [7:0] kind, logic [63:0] ent,
                       logic [63:0] aux, logic [31:0] seq);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {5'd0, seq, aux, ent, kind, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [7:0]  kinds[16];
      logic [63:0] ents[16], auxs[16];
      logic [31:0] seqs[16];
      int n, nload, flaw, spot, done;
      logic [63:0] ones;
      ones = '1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: field extremes, every mode but reset-live, each verify outcome.
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_SPARE6, 8'hff, ones, ones, '1);
      send(MODE_SPARE7, 0, 0, 0, 0);
      send(MODE_RECORD, 8'h00, 0, 0, 0);
      send(MODE_RECORD, 8'hff, ones, ones, '1);
      send(MODE_LOAD_REF, 8'h00, 0, 0, 0);            // load without begin
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_LOAD_REF, 8'hff, ones, ones, 32'd1);
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_BEGIN_REF, 0, 0, 0, 0);
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_LOAD_REF, 8'h01, 0, 0, 0);
      send(MODE_LOAD_REF, 8'hff, ones, ones, 32'd1);
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_BEGIN_REF, 0, 0, 0, 0);
      send(MODE_LOAD_REF, 8'h00, 0, 0, 0);
      send(MODE_LOAD_REF, 8'hff, 64'h1, ones, 32'd1);
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_BEGIN_REF, 0, 0, 0, 0);
      send(MODE_LOAD_REF, 8'h00, 0, 0, 0);
      send(MODE_LOAD_REF, 8'hff, ones, 64'h0, 32'd1);
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_BEGIN_REF, 0, 0, 0, 0);
      send(MODE_LOAD_REF, 8'h00, 0, 0, 32'hffff_fffe);
      send(MODE_LOAD_REF, 8'hff, ones, ones, 32'd1);
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_DROP_REF, 0, 0, 0, 0);
      send(MODE_VERIFY, 0, 0, 0, 0);

      // Hold until everything is back, then overfill both stores.
      drain();
      send(MODE_RESET_LIVE, 0, 0, 0, 0);
      send(MODE_BEGIN_REF, 0, 0, 0, 0);
      for (int i = 0; i < DEPTH + 3; i++) begin
         kinds[0] = 8'($urandom);
         ents[0] = rand64();
         auxs[0] = rand64();
         send(MODE_RECORD, kinds[0], ents[0], auxs[0], $urandom);
         send(MODE_LOAD_REF, kinds[0], ents[0], auxs[0], i);
      end
      send(MODE_VERIFY, 0, 0, 0, 0);
      send(MODE_RECORD, 0, 0, 0, 0);
      send(MODE_VERIFY, 0, 0, 0, 0);

      // Random: mostly well-formed record/load/verify runs with planted flaws.
      done = 0;
      while (done < RANDOM_ITEMS) begin
         if (done > RANDOM_ITEMS - 50) quiet = 1;
         if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(0, 12);
            flaw = $urandom_range(0, 6);
            send(MODE_RESET_LIVE, 0, 0, 0, 0);
            if ($urandom_range(0, 3) == 0) send(MODE_DROP_REF, 0, 0, 0, 0);
            else send(MODE_BEGIN_REF, 0, 0, 0, 0);
            for (int i = 0; i < n; i++) begin
               kinds[i] = 8'($urandom);
               ents[i] = rand64();
               auxs[i] = rand64();
               seqs[i] = i;
               send(MODE_RECORD, kinds[i], ents[i], auxs[i], $urandom);
            end
            nload = n;
            spot = n > 0 ? $urandom_range(0, n - 1) : 0;
            if (n > 0) begin
               case (flaw)
                  1: nload = $urandom_range(0, 1) ? n - 1 : n + 1;
                  2: kinds[spot] = kinds[spot] ^ (8'h1 << $urandom_range(0, 7));
                  3: ents[spot] = ents[spot] ^ (64'h1 << $urandom_range(0, 63));
                  4: auxs[spot] = auxs[spot] ^ (64'h1 << $urandom_range(0, 63));
                  5: seqs[spot] = $urandom;
                  default: ;
               endcase
            end
            for (int i = 0; i < nload; i++) begin
               if (i < n) send(MODE_LOAD_REF, kinds[i], ents[i], auxs[i], seqs[i]);
               else send(MODE_LOAD_REF, 8'($urandom), rand64(), rand64(), $urandom);
            end
            send(MODE_VERIFY, 8'($urandom), rand64(), rand64(), $urandom);
            done += n + nload + 3;
         end else begin
            send(3'($urandom_range(0, 7)), 8'($urandom), rand64(), rand64(), $urandom);
            done++;
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("%0d transactions; verify match/len/kind/ent/aux/digest %0d/%0d/%0d/%0d/%0d/%0d",
               accepted, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
      $display("covered full-store overflow, loads without begin, drops and spare modes");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

/* trace_digest_replay_checker.f */
hw/rtl/tdrc_pkg.sv
hw/rtl/tdrc_ram.sv
hw/rtl/trace_digest_replay_checker.sv
hw/rtl/tdrc_checker.sv
sim/trace_digest_replay_checker_test.sv
